// ===== src/push_tap_detector_core_defines.svh =====
// assertion macros of the push tap detector checker
`ifndef PUSH_TAP_DETECTOR_CORE_DEFINES_SVH
`define PUSH_TAP_DETECTOR_CORE_DEFINES_SVH

// clocked check, muted while reset is asserted
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds through reset
`define PTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/ptd_pkg.sv =====
// types, widths and constants of the push tap detector
package ptd_pkg;

  localparam int COORD_W    = 16;
  localparam int SCALE_W    = COORD_W + 1;
  localparam int TIME_W     = 32;
  localparam int REQ_W      = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int HIST_DEPTH = 8;
  localparam int HALF       = HIST_DEPTH / 2;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = SCALE_W + $clog2(HALF);

  // squared distance and its root
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int ROOT_PAD_W = 2 * SCALE_W;
  localparam int REM_W      = SCALE_W + 3;
  localparam int ROOT_CNT_W = $clog2(SCALE_W);

  // shared bit-serial multiplier
  localparam int MUL_A_W    = (SUM_W > COORD_W) ? SUM_W : COORD_W;
  localparam int MUL_B_W    = COORD_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = $clog2(MUL_B_W);

  localparam logic [7:0]  RISE_RST     = 8'd38;
  localparam logic [7:0]  RELEASE_RST  = 8'd225;
  localparam logic [15:0] MAX_DUR_RST  = 16'd300;
  localparam logic [15:0] COOLDOWN_RST = 16'd500;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOST = 2'd0,
    REQ_POSE = 2'd1,
    REQ_NAV  = 2'd2,
    REQ_HOLD = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_RISE     = 2'd0,
    REG_RELEASE  = 2'd1,
    REG_MAX_DUR  = 2'd2,
    REG_COOLDOWN = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_PUSH,
    ST_SUM,
    ST_LOAD,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

// ===== src/ptd_intf.sv =====
// frame and result channel interfaces of the push tap detector
interface ptd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptd_pkg::REQ_W-1:0]    req_type;
  logic [ptd_pkg::COORD_W-1:0]  wrist_x;
  logic [ptd_pkg::COORD_W-1:0]  wrist_y;
  logic [ptd_pkg::COORD_W-1:0]  palm_x;
  logic [ptd_pkg::COORD_W-1:0]  palm_y;
  logic [ptd_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, req_type, wrist_x, wrist_y, palm_x, palm_y, now_ms,
                  input ready);
  modport sink (input valid, req_type, wrist_x, wrist_y, palm_x, palm_y, now_ms,
                output ready);
endinterface

interface ptd_out_if;
  logic valid;
  logic ready;
  logic tap;
  logic armed;

  modport source (output valid, tap, armed, input ready);
  modport sink (input valid, tap, armed, output ready);
endinterface

// ===== src/ptd_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ptd_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ptd_pkg::MUL_A_W-1:0] a_i,
  input  logic [ptd_pkg::MUL_B_W-1:0] b_i,
  output logic                        done_o,
  output logic [ptd_pkg::PROD_W-1:0]  p_o
);
  import ptd_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [PROD_W-1:0]    a_sh_q;
  logic [MUL_B_W-1:0]   b_sh_q;
  logic [PROD_W-1:0]    acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_sh_q <= PROD_W'(a_i);
      b_sh_q <= b_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (b_sh_q[0]) begin
        acc_q <= acc_q + a_sh_q;
      end
      a_sh_q <= {a_sh_q[PROD_W-2:0], 1'b0};
      b_sh_q <= {1'b0, b_sh_q[MUL_B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== src/ptd_isqrt.sv =====
// integer square root, one root bit per cycle
module ptd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ptd_pkg::SQ_W-1:0]    val_i,
  output logic                        done_o,
  output logic [ptd_pkg::SCALE_W-1:0] root_o
);
  import ptd_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic [ROOT_PAD_W-1:0] val_sh_q;
  logic [REM_W-1:0]      rem_q;
  logic [SCALE_W-1:0]    root_q;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  fits;

  // bring down the next two bits, try root*4+1
  assign rem_sh = {rem_q[REM_W-3:0], val_sh_q[ROOT_PAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ROOT_CNT_W'(SCALE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_sh_q <= ROOT_PAD_W'(val_i);
      rem_q    <= '0;
      root_q   <= '0;
    end else if (busy_q) begin
      val_sh_q <= {val_sh_q[ROOT_PAD_W-3:0], 2'b00};
      rem_q    <= fits ? rem_sh - trial : rem_sh;
      root_q   <= {root_q[SCALE_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/push_tap_detector_core.sv =====
// push tap detector: hand scale history, arm on a rise, tap on a quick release
//
//   channel   dir   handshake              beat contents
//   in_if     in    valid/ready            req_type, wrist/palm x,y, now_ms
//   out_if    out   valid/ready            tap, armed
//   apb       in    psel/penable/pwrite    four config registers at 4*i
//
// a navigation frame squares both offsets bit-serially in parallel, then takes
// the bit-serial root; once the history is full it also runs the history sum
// (HIST_DEPTH/2 entries) and the two threshold products; other frame kinds go
// straight to the result.
// one frame is in flight at a time; the next is taken while a result waits.
// a stalled result holds the block in its last state until taken.
// reset clears control state and loads register defaults; no clearing pass.
module push_tap_detector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ptd_in_if.sink                         in_if,
  ptd_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ptd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ptd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ptd_pkg::*;

  // configuration
  logic [7:0]  rise_q;
  logic [7:0]  release_q;
  logic [15:0] max_dur_q;
  logic [15:0] cooldown_q;
  cfg_reg_e    cfg_sel;

  // control and detector state
  state_e               state_q, state_d;
  logic                 in_acc;
  logic                 mul_start;
  logic                 root_start;
  logic [FILL_W-1:0]    fill_q;
  logic                 armed_q;
  logic [SCALE_W-1:0]   peak_q;
  logic [TIME_W-1:0]    armed_since_q;
  logic [TIME_W-1:0]    last_tap_q;
  logic                 tap_seen_q;
  logic                 res_tap_q;
  logic [HIST_IDX_W-1:0] sum_idx_q;
  logic                 out_valid_q;
  logic                 out_tap_q;
  logic                 out_armed_q;
  logic                 out_free;

  // payload
  logic [TIME_W-1:0]    now_q;
  logic [SCALE_W-1:0]   cur_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SCALE_W-1:0]   hist_q [HIST_DEPTH];

  // datapath
  logic [COORD_W-1:0]   dx, dy;
  logic [MUL_A_W-1:0]   mx_a, my_a;
  logic [MUL_B_W-1:0]   mx_b, my_b;
  logic                 mx_done, my_done;
  logic [PROD_W-1:0]    px, py;
  logic [SQ_W-1:0]      sq;
  logic                 root_done;
  logic [SCALE_W-1:0]   root;
  logic                 fill_room;
  logic                 full_after;
  logic                 sum_last;
  logic [PROD_W-1:0]    arm_lhs;
  logic [PROD_W-1:0]    rel_lhs;
  logic [TIME_W-1:0]    held;
  logic [TIME_W-1:0]    since_tap;
  logic                 do_arm, too_long, released, cool_ok;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q     <= RISE_RST;
      release_q  <= RELEASE_RST;
      max_dur_q  <= MAX_DUR_RST;
      cooldown_q <= COOLDOWN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        REG_RISE:     rise_q     <= pwdata[7:0];
        REG_RELEASE:  release_q  <= pwdata[7:0];
        REG_MAX_DUR:  max_dur_q  <= pwdata[15:0];
        REG_COOLDOWN: cooldown_q <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_RISE:     prdata = CFG_DATA_W'(rise_q);
      REG_RELEASE:  prdata = CFG_DATA_W'(release_q);
      REG_MAX_DUR:  prdata = CFG_DATA_W'(max_dur_q);
      REG_COOLDOWN: prdata = CFG_DATA_W'(cooldown_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- serial arithmetic ----------------
  assign dx = (in_if.wrist_x > in_if.palm_x) ? in_if.wrist_x - in_if.palm_x
                                             : in_if.palm_x - in_if.wrist_x;
  assign dy = (in_if.wrist_y > in_if.palm_y) ? in_if.wrist_y - in_if.palm_y
                                             : in_if.palm_y - in_if.wrist_y;

  // lanes square the offsets first, then form the two threshold products
  always_comb begin
    if (state_q == ST_IDLE) begin
      mx_a = MUL_A_W'(dx);
      mx_b = dx;
      my_a = MUL_A_W'(dy);
      my_b = dy;
    end else begin
      mx_a = MUL_A_W'(sum_q);
      mx_b = MUL_B_W'({1'b1, rise_q});
      my_a = MUL_A_W'(peak_q);
      my_b = MUL_B_W'(release_q);
    end
  end

  ptd_mul u_mul_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mx_a),
    .b_i     (mx_b),
    .done_o  (mx_done),
    .p_o     (px)
  );

  ptd_mul u_mul_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (my_a),
    .b_i     (my_b),
    .done_o  (my_done),
    .p_o     (py)
  );

  assign sq = SQ_W'(px[2*COORD_W-1:0]) + SQ_W'(py[2*COORD_W-1:0]);

  ptd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .val_i   (sq),
    .done_o  (root_done),
    .root_o  (root)
  );

  // ---------------- decision terms ----------------
  assign fill_room  = fill_q < FILL_W'(HIST_DEPTH);
  assign full_after = fill_q >= FILL_W'(HIST_DEPTH - 1);
  assign sum_last   = sum_idx_q == HIST_IDX_W'(HALF - 1);

  assign arm_lhs   = PROD_W'(cur_q) * PROD_W'(HALF * 256);
  assign rel_lhs   = PROD_W'({cur_q, 8'b0});
  assign held      = now_q - armed_since_q;
  assign since_tap = now_q - last_tap_q;

  // zero baseline never arms
  assign do_arm   = (sum_q != '0) && (arm_lhs > px);
  assign too_long = held > TIME_W'(max_dur_q);
  assign released = rel_lhs < py;
  assign cool_ok  = !tap_seen_q || (since_tap >= TIME_W'(cooldown_q));

  // ---------------- sequencer ----------------
  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d     = state_q;
    in_if.ready = 1'b0;
    mul_start   = 1'b0;
    root_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          if (in_if.req_type == REQ_NAV) begin
            mul_start = 1'b1;
            state_d   = ST_SQUARE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SQUARE: begin
        if (mx_done) begin
          root_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        state_d = full_after ? ST_SUM : ST_DONE;
      end
      ST_SUM: begin
        if (sum_last) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (my_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      armed_q       <= 1'b0;
      peak_q        <= '0;
      armed_since_q <= '0;
      last_tap_q    <= '0;
      tap_seen_q    <= 1'b0;
      res_tap_q     <= 1'b0;
      sum_idx_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          res_tap_q <= 1'b0;
          if (in_acc && (in_if.req_type == REQ_LOST || in_if.req_type == REQ_POSE)) begin
            fill_q  <= '0;
            armed_q <= 1'b0;
          end
        end
        ST_PUSH: begin
          if (fill_room) fill_q <= fill_q + 1'b1;
          sum_idx_q <= '0;
        end
        ST_SUM: begin
          sum_idx_q <= sum_idx_q + 1'b1;
        end
        ST_MUL: begin
          if (my_done) begin
            if (!armed_q) begin
              if (do_arm) begin
                armed_q       <= 1'b1;
                peak_q        <= cur_q;
                armed_since_q <= now_q;
              end
            end else if (too_long) begin
              armed_q <= 1'b0;
            end else if (released) begin
              armed_q <= 1'b0;
              if (cool_ok) begin
                last_tap_q <= now_q;
                tap_seen_q <= 1'b1;
                res_tap_q  <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // frame payload and scale history
  always_ff @(posedge clk_i) begin
    if (in_acc) now_q <= in_if.now_ms;
    if (state_q == ST_ROOT && root_done) cur_q <= root;
    if (state_q == ST_PUSH) begin
      sum_q <= '0;
      if (fill_room) begin
        hist_q[fill_q[HIST_IDX_W-1:0]] <= cur_q;
      end else begin
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[HIST_DEPTH-1] <= cur_q;
      end
    end
    // baseline: older half of the history, one entry a cycle
    if (state_q == ST_SUM) sum_q <= sum_q + SUM_W'(hist_q[sum_idx_q]);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_tap_q   <= 1'b0;
      out_armed_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
      out_tap_q   <= res_tap_q;
      out_armed_q <= armed_q;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.tap   = out_tap_q;
  assign out_if.armed = out_armed_q;

endmodule

// ===== src/ptd_checker.sv =====
// port-level checks of the push tap detector and their bind
`include "push_tap_detector_core_defines.svh"

module ptd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic tap_i,
  input logic armed_i
);

  `PTD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(tap_i) && $stable(armed_i), "result beat changed while stalled")

  `PTD_ASSERT(a_tap_disarms, out_valid_i && tap_i |-> !armed_i, "tap reported while still armed")

  `PTD_ASSERT(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i, "frame taken while another is in work")

  `PTD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i, "result beat offered during reset")

endmodule

bind push_tap_detector_core ptd_checker u_ptd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .tap_i       (out_if.tap),
  .armed_i     (out_if.armed)
);

// ===== tb/sv/push_tap_detector_core_tb.sv =====
// self-checking testbench of the push tap detector core
`timescale 1ns / 100ps

module push_tap_detector_core_tb;
  import ptd_pkg::*;

  typedef struct {
    req_e        kind;
    logic [15:0] wrist_x;
    logic [15:0] wrist_y;
    logic [15:0] palm_x;
    logic [15:0] palm_y;
    logic [31:0] now_ms;
  } frame_t;

  typedef struct {
    logic tap;
    logic armed;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  ptd_in_if  frame_if ();
  ptd_out_if verdict_if ();

  push_tap_detector_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (frame_if),
    .out_if  (verdict_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_t   frame_q[$];
  verdict_t verdict_q[$];
  frame_t   offered;

  // predictor copy of the registers and the detector state
  logic [7:0]  cfg_rise;
  logic [7:0]  cfg_release;
  logic [15:0] cfg_max_dur;
  logic [15:0] cfg_cooldown;
  logic [16:0] scale_hist[HIST_DEPTH];
  int          hist_fill;
  longint unsigned older_sum;
  logic        pred_armed;
  logic [16:0] peak;
  logic [31:0] armed_at;
  logic [31:0] last_tap_at;
  logic        tap_done;

  logic [31:0] clock_ms;
  int unsigned idle_pct_in;
  int unsigned idle_pct_out;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned hold_left;
  logic        hold_go;
  int unsigned errors;
  int unsigned checked;
  int unsigned taps_seen;
  int unsigned armed_beats;
  int unsigned settings;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [16:0] root_of(longint unsigned v);
    logic [16:0] r;
    longint unsigned t;
    int b;
    r = '0;
    for (b = 16; b >= 0; b--) begin
      t = longint'(r) | (64'd1 << b);
      if (t * t <= v) r = t[16:0];
    end
    return r;
  endfunction

  function automatic verdict_t detect_push(frame_t f);
    verdict_t v;
    longint unsigned dx, dy;
    logic [16:0] scale;
    logic [31:0] held, since_tap;
    int k;
    v.tap = 1'b0;
    case (f.kind)
      REQ_LOST, REQ_POSE: begin
        for (k = 0; k < HIST_DEPTH; k++) scale_hist[k] = '0;
        hist_fill = 0;
        older_sum = 0;
        pred_armed = 1'b0;
      end
      REQ_NAV: begin
        dx = (f.palm_x > f.wrist_x) ? f.palm_x - f.wrist_x : f.wrist_x - f.palm_x;
        dy = (f.palm_y > f.wrist_y) ? f.palm_y - f.wrist_y : f.wrist_y - f.palm_y;
        scale = root_of(dx * dx + dy * dy);
        if (hist_fill < HIST_DEPTH) begin
          scale_hist[hist_fill] = scale;
          hist_fill++;
        end else begin
          for (k = 0; k < HIST_DEPTH - 1; k++) scale_hist[k] = scale_hist[k + 1];
          scale_hist[HIST_DEPTH - 1] = scale;
        end
        if (hist_fill == HIST_DEPTH) begin
          older_sum = 0;
          for (k = 0; k < HALF; k++) older_sum += scale_hist[k];
          if (!pred_armed) begin
            // ratio against the older-half mean, kept in integers
            if (older_sum != 0 &&
                longint'(scale) * 256 * HALF > older_sum * (256 + cfg_rise)) begin
              pred_armed = 1'b1;
              peak = scale;
              armed_at = f.now_ms;
            end
          end else begin
            held = f.now_ms - armed_at;
            since_tap = f.now_ms - last_tap_at;
            if (held > cfg_max_dur) begin
              pred_armed = 1'b0;
            end else if (longint'(scale) * 256 < longint'(peak) * cfg_release) begin
              pred_armed = 1'b0;
              if (!tap_done || since_tap >= cfg_cooldown) begin
                last_tap_at = f.now_ms;
                tap_done = 1'b1;
                v.tap = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    v.armed = pred_armed;
    return v;
  endfunction

  // sender: one beat offered at a time, random gaps between beats
  always @(posedge clk_i) begin : frame_driver
    logic offer;
    if (!rst_ni) begin
      frame_if.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (frame_if.valid && frame_if.ready)
        verdict_q.insert(verdict_q.size(), detect_push(offered));
      if (!frame_if.valid || frame_if.ready) begin
        offer = 1'b0;
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (frame_q.size() != 0) begin
          if (idle_pct_in != 0 && $urandom_range(99) < idle_pct_in) begin
            in_gap <= $urandom_range(0, 5);
          end else begin
            offer = 1'b1;
            offered = frame_q[0];
            frame_q.delete(0);
          end
        end
        frame_if.valid <= offer;
        if (offer) begin
          frame_if.req_type <= offered.kind;
          frame_if.wrist_x  <= offered.wrist_x;
          frame_if.wrist_y  <= offered.wrist_y;
          frame_if.palm_x   <= offered.palm_x;
          frame_if.palm_y   <= offered.palm_y;
          frame_if.now_ms   <= offered.now_ms;
        end
      end
    end
  end

  // long receiver hold-off, so the block fills up and stalls its input
  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 500;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin : verdict_monitor
    verdict_t want;
    logic rdy;
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        checked++;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result beat with no frame pending (tap %0b armed %0b)",
                     verdict_if.tap, verdict_if.armed);
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (want.tap) taps_seen++;
          if (want.armed) armed_beats++;
          if (verdict_if.tap !== want.tap || verdict_if.armed !== want.armed) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d tap %0b armed %0b, expected tap %0b armed %0b",
                       checked, verdict_if.tap, verdict_if.armed, want.tap, want.armed);
          end
        end
      end
      rdy = 1'b1;
      if (hold_left != 0) begin
        rdy = 1'b0;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        rdy = 1'b0;
      end else if (idle_pct_out != 0 && $urandom_range(99) < idle_pct_out) begin
        out_gap <= $urandom_range(0, 5);
        rdy = 1'b0;
      end
      verdict_if.ready <= rdy;
    end
  end

  task automatic cfg_write(cfg_reg_e r, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_RISE:     cfg_rise     = val[7:0];
      REG_RELEASE:  cfg_release  = val[7:0];
      REG_MAX_DUR:  cfg_max_dur  = val[15:0];
      REG_COOLDOWN: cfg_cooldown = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned rise, int unsigned rel, int unsigned dur,
                          int unsigned cool);
    cfg_write(REG_RISE, rise);
    cfg_write(REG_RELEASE, rel);
    cfg_write(REG_MAX_DUR, dur);
    cfg_write(REG_COOLDOWN, cool);
    settings++;
  endtask

  task automatic add_frame(req_e kind, int unsigned wx, int unsigned wy,
                           int unsigned px, int unsigned py, int unsigned dt);
    frame_t f;
    clock_ms += dt;
    f.kind = kind;
    f.wrist_x = 16'(wx);
    f.wrist_y = 16'(wy);
    f.palm_x = 16'(px);
    f.palm_y = 16'(py);
    f.now_ms = clock_ms;
    frame_q.insert(frame_q.size(), f);
  endtask

  // navigation frame whose wrist-to-palm distance is about s
  task automatic add_nav(int unsigned s, int unsigned dt);
    int unsigned dx, dy, wx, wy, px, py;
    if (s > 65535) s = 65535;
    dx = $urandom_range(0, s);
    dy = 32'(root_of(longint'(s) * s - longint'(dx) * dx));
    wx = $urandom_range(0, 65535 - dx);
    wy = $urandom_range(0, 65535 - dy);
    px = wx + dx;
    py = wy + dy;
    if ($urandom_range(1)) add_frame(REQ_NAV, wx, wy, px, py, dt);
    else add_frame(REQ_NAV, px, py, wx, wy, dt);
  endtask

  function automatic int unsigned any_coord();
    case ($urandom_range(7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // steady hand, a push toward the camera, then a release or a linger
  task automatic add_push();
    int unsigned base, top, n;
    base = ($urandom_range(7) == 0) ? $urandom_range(1, 60000) : $urandom_range(20, 3000);
    n = $urandom_range(4, 9);
    repeat (n) add_nav(base - base / 32 + $urandom_range(0, base / 16), $urandom_range(15, 45));
    top = base * $urandom_range(240, 620) / 256;
    add_nav(top, $urandom_range(15, 45));
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(3) == 0)
        add_frame(REQ_HOLD, any_coord(), any_coord(), any_coord(), any_coord(),
                  $urandom_range(10, 40));
      else
        add_nav(top * $urandom_range(200, 270) / 256, $urandom_range(10, 60));
    end
    add_nav(top * $urandom_range(0, 300) / 256,
            ($urandom_range(3) == 0) ? $urandom_range(100, 2000) : $urandom_range(5, 250));
    if ($urandom_range(5) == 0)
      add_frame(($urandom_range(1) != 0) ? REQ_LOST : REQ_POSE, any_coord(), any_coord(),
                any_coord(), any_coord(), $urandom_range(0, 100));
    clock_ms += $urandom_range(0, 900);
  endtask

  task automatic add_noise();
    int unsigned dt;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(3) == 0) begin
        clock_ms = $urandom();
        dt = 0;
      end else begin
        dt = $urandom_range(0, 80);
      end
      add_frame(req_e'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord(),
                any_coord(), dt);
    end
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || frame_if.valid || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_frames, int unsigned pct_in, int unsigned pct_out,
                           bit long_hold);
    int unsigned stop;
    idle_pct_in = pct_in;
    idle_pct_out = pct_out;
    if ($urandom_range(2) == 0) clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4000);
    stop = frame_q.size() + n_frames;
    while (frame_q.size() < stop) begin
      case ($urandom_range(9))
        7, 8:    add_noise();
        9:       add_frame(($urandom_range(1) != 0) ? REQ_LOST : REQ_POSE, any_coord(),
                           any_coord(), any_coord(), any_coord(), $urandom_range(0, 60));
        default: add_push();
      endcase
    end
    if (long_hold) begin
      repeat (200) @(posedge clk_i);
      hold_go <= 1'b1;
      @(posedge clk_i);
      hold_go <= 1'b0;
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    frame_if.valid = 1'b0;
    frame_if.req_type = REQ_LOST;
    frame_if.wrist_x = '0;
    frame_if.wrist_y = '0;
    frame_if.palm_x = '0;
    frame_if.palm_y = '0;
    frame_if.now_ms = '0;
    verdict_if.ready = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    idle_pct_in = 20;
    idle_pct_out = 20;
    errors = 0;
    checked = 0;
    taps_seen = 0;
    armed_beats = 0;
    settings = 1;
    cfg_rise = RISE_RST;
    cfg_release = RELEASE_RST;
    cfg_max_dur = MAX_DUR_RST;
    cfg_cooldown = COOLDOWN_RST;
    foreach (scale_hist[k]) scale_hist[k] = '0;
    hist_fill = 0;
    older_sum = 0;
    pred_armed = 1'b0;
    peak = '0;
    armed_at = '0;
    last_tap_at = '0;
    tap_done = 1'b0;
    clock_ms = 32'd1000;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // clears and hold at the coordinate extremes
    add_frame(REQ_LOST, 65535, 0, 65535, 0, 0);
    add_frame(REQ_POSE, 0, 65535, 0, 65535, 30);
    add_frame(REQ_HOLD, 65535, 65535, 65535, 65535, 30);
    // zero baseline: eight zero-length hands, then the longest one never arms
    add_frame(REQ_NAV, 0, 0, 0, 0, 30);
    add_frame(REQ_NAV, 65535, 65535, 65535, 65535, 30);
    repeat (6) add_frame(REQ_NAV, 12345, 54321, 12345, 54321, 30);
    add_frame(REQ_NAV, 0, 0, 65535, 65535, 30);
    add_frame(REQ_LOST, 0, 0, 0, 0, 30);
    // steady history, arm on a push, tap on the release
    repeat (8) add_nav(100, 30);
    add_frame(REQ_NAV, 65535, 65535, 65335, 65535, 30);
    add_nav(100, 30);
    // second push released inside the cooldown: no tap
    add_nav(300, 30);
    add_nav(50, 30);
    drain();

    run_phase(130, 20, 20, 1'b0);
    set_regs(1, 255, 65535, 0);
    run_phase(130, 25, 10, 1'b1);
    set_regs(255, 1, 1, 65535);
    run_phase(90, 35, 0, 1'b0);
    set_regs(0, 0, $urandom_range(1, 65535), $urandom_range(0, 65535));
    run_phase(80, 0, 30, 1'b0);
    repeat (2) begin
      set_regs($urandom_range(1, 255), $urandom_range(150, 255), $urandom_range(40, 1000),
               $urandom_range(0, 1500));
      run_phase(115, $urandom_range(0, 40), $urandom_range(0, 40), 1'b0);
    end
    // closing stretch at the reset values, no idling on either side
    set_regs(RISE_RST, RELEASE_RST, MAX_DUR_RST, COOLDOWN_RST);
    run_phase(135, 0, 0, 1'b0);

    $display("checked %0d result beats over %0d register settings", checked, settings);
    $display("%0d taps and %0d armed beats predicted, %0d mismatches",
             taps_seen, armed_beats, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ptd_pkg.sv
src/ptd_intf.sv
src/ptd_mul.sv
src/ptd_isqrt.sv
src/push_tap_detector_core.sv
src/ptd_checker.sv
tb/sv/push_tap_detector_core_tb.sv
